// ----- hdl/dlt_pkg.sv -----
`timescale 1ns / 1ps
package dlt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int AMT_W       = 24;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int STEP_W      = CNT_W + 1;
  localparam int OUT_CNT_W   = 5;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic             start;
    logic             step;
    logic             proc;
    logic             in_list;
    logic             op;
    logic [AMT_W-1:0] amount;
  } walk_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] gone_next;
  } walk_sts_t;

endpackage

// ----- hdl/dlt_in_if.sv -----
`timescale 1ns / 1ps
interface dlt_in_if
  import dlt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             op;
  logic [AMT_W-1:0] amount;

  modport source (output valid, output op, output amount, input ready);
  modport sink   (input valid, input op, input amount, output ready);
endinterface

// ----- hdl/dlt_out_if.sv -----
`timescale 1ns / 1ps
interface dlt_out_if
  import dlt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [OUT_CNT_W-1:0] expired_count;
  logic [OUT_CNT_W-1:0] active_count;
  logic [AMT_W-1:0]     head_delay;

  modport source (output valid, output accepted, output expired_count,
                  output active_count, output head_delay, input ready);
  modport sink   (input valid, input accepted, input expired_count,
                  input active_count, input head_delay, output ready);
endinterface

// ----- hdl/delta_list_timer_queue_unit.sv -----
`timescale 1ns / 1ps
// an add walks the full ring of delta cells, a rejected add skips the walk, and an advance
// walks the full ring and then rotates on by one cell per expired timer; the ring
// rotates one cell per cycle past the shared walk unit
// one transaction is worked at a time; the next is taken once the result is registered
// reset clears the pending count and control; cell contents are undefined until written
module delta_list_timer_queue_unit
  import dlt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  dlt_in_if.sink    cmd,
  dlt_out_if.source res
);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t            state;
  logic              op;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  pending;
  logic              res_ok;
  logic [CNT_W-1:0]  res_gone;

  logic [AMT_W-1:0]  q [TIMER_SLOTS];
  logic [AMT_W-1:0]  tail;
  logic              shift;
  logic              accept;
  logic              last;
  logic              full;
  walk_ctl_t         ctl;
  walk_sts_t         sts;

  assign cmd.ready = (state == IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (pending == CNT_W'(TIMER_SLOTS));
  assign shift     = (state == RUN);

  always_comb begin
    ctl.start   = accept;
    ctl.step    = shift;
    ctl.proc    = step < STEP_W'(TIMER_SLOTS);
    ctl.in_list = step < STEP_W'(pending);
    ctl.op      = op;
    ctl.amount  = cmd.amount;
  end

  assign last = (op == OP_ADD) ? (step == STEP_W'(TIMER_SLOTS - 1))
              : (step == STEP_W'(TIMER_SLOTS - 1) + STEP_W'(sts.gone_next));

  for (genvar k = 0; k < TIMER_SLOTS; k++) begin : g_cell
    logic [AMT_W-1:0] d;
    if (k == TIMER_SLOTS - 1) begin : g_tail
      assign d = tail;
    end else begin : g_mid
      assign d = q[k+1];
    end
    dlt_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (d),
      .q     (q[k])
    );
  end

  dlt_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .head (q[0]),
    .tail (tail),
    .sts  (sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      pending   <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != DONE) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            op   <= cmd.op;
            step <= '0;
            if (cmd.op == OP_ADD && full) begin
              res_ok   <= 1'b0;
              res_gone <= '0;
              state    <= DONE;
            end else begin
              state <= RUN;
            end
          end
        end
        RUN: begin
          step <= STEP_W'(step + 1'b1);
          if (last) begin
            res_ok <= 1'b1;
            if (op == OP_ADD) begin
              res_gone <= '0;
              pending  <= CNT_W'(pending + 1'b1);
            end else begin
              res_gone <= sts.gone_next;
              pending  <= CNT_W'(pending - sts.gone_next);
            end
            state <= DONE;
          end
        end
        DONE: begin
          if (!res.valid || res.ready) begin
            res.valid         <= 1'b1;
            res.accepted      <= res_ok;
            res.expired_count <= OUT_CNT_W'(res_gone);
            res.active_count  <= OUT_CNT_W'(pending);
            res.head_delay    <= (pending != '0) ? q[0] : '0;
            state             <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(TIMER_SLOTS))
    else $error("pending count exceeds slot count");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.accepted |-> res.active_count == OUT_CNT_W'(TIMER_SLOTS))
    else $error("add rejected while store not full");

  a_gone_bound: assert property (@(posedge clk) disable iff (rst)
    state == RUN |-> sts.gone_next <= pending)
    else $error("more timers expired than pending");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == RUN && last |=> state == DONE && !cmd.ready)
    else $error("walk did not finish into result stage");

endmodule

// ----- hdl/dlt_cell.sv -----
`timescale 1ns / 1ps
module dlt_cell
  import dlt_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic [AMT_W-1:0] d,
  output logic [AMT_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- hdl/dlt_walk.sv -----
`timescale 1ns / 1ps
module dlt_walk
  import dlt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  walk_ctl_t        ctl,
  input  logic [AMT_W-1:0] head,
  output logic [AMT_W-1:0] tail,
  output walk_sts_t        sts
);

  logic [AMT_W-1:0] work, work_next;
  logic [AMT_W-1:0] held, held_next;
  logic             ins, ins_next;
  logic             lead, lead_next;
  logic [CNT_W-1:0] gone, gone_next;

  always_comb begin
    logic [AMT_W-1:0] nx;
    nx        = '0;
    work_next = work;
    held_next = held;
    ins_next  = ins;
    lead_next = lead;
    gone_next = gone;
    tail      = head;
    if (ctl.start) begin
      work_next = ctl.amount;
      ins_next  = 1'b0;
      lead_next = 1'b1;
      gone_next = '0;
    end else if (ctl.step && ctl.proc) begin
      if (ctl.op == OP_ADD) begin
        if (ins) begin
          // entries behind the new timer move down one cell
          tail      = held;
          held_next = head;
        end else if (!ctl.in_list || work <= head) begin
          tail      = work;
          held_next = head - work;
          ins_next  = 1'b1;
        end else begin
          work_next = work - head;
        end
      end else if (ctl.in_list) begin
        if (work > head) begin
          nx        = '0;
          work_next = work - head;
        end else begin
          nx        = head - work;
          work_next = '0;
        end
        tail = nx;
        if (lead && nx == '0) begin
          gone_next = CNT_W'(gone + 1'b1);
        end else begin
          lead_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ins  <= 1'b0;
      lead <= 1'b0;
      gone <= '0;
    end else begin
      ins  <= ins_next;
      lead <= lead_next;
      gone <= gone_next;
    end
    work <= work_next;
    held <= held_next;
  end

  assign sts.gone_next = gone_next;

endmodule

// ----- tb/timer_queue_checker.sv -----
`timescale 1ns / 1ps
module timer_queue_checker
  import dlt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dlt_in_if    cmd,
  dlt_out_if   res,
  output int   fail_count,
  output int   results_due
);

  typedef struct packed {
    logic                 accepted;
    logic [OUT_CNT_W-1:0] expired_count;
    logic [OUT_CNT_W-1:0] active_count;
    logic [AMT_W-1:0]     head_delay;
  } timer_result_t;

  logic [AMT_W-1:0] slot_delta [TIMER_SLOTS];
  int               timers_held;
  timer_result_t    due_results [$];

  // delta-list timer queue: walk, insert or expire, then report the head
  function automatic timer_result_t apply_timer_op(input logic op, input logic [AMT_W-1:0] amt);
    timer_result_t    r;
    int               pos;
    int               gone;
    int               k;
    logic [AMT_W-1:0] rest;
    pos = 0;
    gone = 0;
    rest = amt;
    r.accepted = 1'b1;
    if (op == OP_ADD) begin
      if (timers_held >= TIMER_SLOTS) begin
        r.accepted = 1'b0;
      end else begin
        while (pos < timers_held && rest > slot_delta[pos]) begin
          rest -= slot_delta[pos];
          pos++;
        end
        if (pos < timers_held) slot_delta[pos] -= rest;
        for (k = timers_held; k > pos; k--) slot_delta[k] = slot_delta[k-1];
        slot_delta[pos] = rest;
        timers_held++;
      end
    end else begin
      while (pos < timers_held && rest > slot_delta[pos]) begin
        rest -= slot_delta[pos];
        slot_delta[pos] = '0;
        pos++;
      end
      if (pos < timers_held) slot_delta[pos] -= rest;
      while (gone < timers_held && slot_delta[gone] == '0) gone++;
      for (k = gone; k < timers_held; k++) slot_delta[k-gone] = slot_delta[k];
      timers_held -= gone;
    end
    r.expired_count = OUT_CNT_W'(gone);
    r.active_count  = OUT_CNT_W'(timers_held);
    r.head_delay    = (timers_held > 0) ? slot_delta[0] : '0;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    results_due = 0;
    timers_held = 0;
    foreach (slot_delta[i]) slot_delta[i] = '0;
  end

  always @(posedge clk) begin
    timer_result_t want;
    timer_result_t got;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got = '{res.accepted, res.expired_count, res.active_count, res.head_delay};
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result acc=%0d exp=%0d act=%0d head=%0d", $time,
                     got.accepted, got.expired_count, got.active_count, got.head_delay);
        end else begin
          want = due_results.pop_front();
          if (got.accepted !== want.accepted || got.expired_count !== want.expired_count ||
              got.active_count !== want.active_count || got.head_delay !== want.head_delay) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%0t: mismatch expected acc=%0d exp=%0d act=%0d head=%0d, ", $time,
                     want.accepted, want.expired_count, want.active_count, want.head_delay);
              $display("got acc=%0d exp=%0d act=%0d head=%0d", got.accepted,
                       got.expired_count, got.active_count, got.head_delay);
            end
          end
        end
      end
      if (cmd.valid && cmd.ready) due_results.push_back(apply_timer_op(cmd.op, cmd.amount));
      results_due = due_results.size();
    end
  end

endmodule

// ----- tb/tb_delta_list_timer_queue_unit.sv -----
`timescale 1ns / 1ps
module tb_delta_list_timer_queue_unit;
  import dlt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 2 * TIMER_SLOTS + 8;
  localparam int PHASE_ITEMS    = 406;

  logic clk;
  logic rst;
  int   fail_count;
  int   results_due;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_req;
  int   stall_cycles;

  logic [AMT_W-1:0] recent_delay [8];

  dlt_in_if  cmd ();
  dlt_out_if res ();

  delta_list_timer_queue_unit u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  timer_queue_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .res         (res),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver side, with a long hold-off on request
  initial begin
    res.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          res.ready <= 1'b0;
          @(negedge clk);
        end
      end else begin
        res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_timer_op(input logic op_sel, input logic [AMT_W-1:0] amt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid  <= 1'b1;
    cmd.op     <= op_sel;
    cmd.amount <= amt;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [AMT_W-1:0] pick_amount(input logic op_sel);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return AMT_W'($urandom_range(0, 63));
    if (sel < 60) return AMT_W'($urandom_range(0, 4095));
    if (sel < 80) return AMT_W'($urandom);
    if (sel < 90) begin
      // repeated delays land on equal expiry times
      if (op_sel == OP_ADD) return recent_delay[$urandom_range(0, 7)];
      return AMT_W'($urandom_range(0, 3));
    end
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return AMT_W'(1) << $urandom_range(0, AMT_W - 1);
    endcase
  endfunction

  task automatic run_random_ops(input int n);
    int               add_pct;
    logic             op_sel;
    logic [AMT_W-1:0] amt;
    add_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) add_pct = $urandom_range(20, 85);
      op_sel = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_ADVANCE;
      amt = pick_amount(op_sel);
      if (op_sel == OP_ADD) recent_delay[$urandom_range(0, 7)] = amt;
      send_timer_op(op_sel, amt);
    end
  endtask

  initial begin
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.op = OP_ADD;
    cmd.amount = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    stall_cycles = 0;
    foreach (recent_delay[i]) recent_delay[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue, zero delay, equal delays, append, huge advance
    send_timer_op(OP_ADVANCE, '0);
    send_timer_op(OP_ADVANCE, '1);
    send_timer_op(OP_ADD, '0);
    send_timer_op(OP_ADVANCE, '0);
    send_timer_op(OP_ADD, AMT_W'(100));
    send_timer_op(OP_ADD, AMT_W'(100));
    send_timer_op(OP_ADD, AMT_W'(50));
    send_timer_op(OP_ADD, AMT_W'(300));
    send_timer_op(OP_ADD, '1);
    send_timer_op(OP_ADVANCE, '1);
    // fill the store, then one add too many
    for (int i = 0; i < TIMER_SLOTS; i++)
      send_timer_op(OP_ADD, (i % 2) ? '1 : AMT_W'(i * 7));
    send_timer_op(OP_ADD, '0);

    hold_req = 1'b1;
    run_random_ops(PHASE_ITEMS);

    send_idle_pct = 69;
    recv_stall_pct = 0;
    run_random_ops(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_stall_pct = 69;
    run_random_ops(PHASE_ITEMS);

    send_idle_pct = 30;
    recv_stall_pct = 30;
    run_random_ops(PHASE_ITEMS);

    cmd.valid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
